/* design/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg: shared types and constants of the byte pattern scanner
// Widths of the stream, result and configuration fields, register indexes.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int PATTERN_MAX    = 32;
  localparam int HIST_DEPTH     = PATTERN_MAX - 1;
  localparam int LEN_W          = 6;
  localparam int IDX_W          = 5;
  localparam int BYTE_W         = 8;
  localparam int ADDR_W         = 64;
  localparam int REGION_W       = 16;
  localparam int OFFSET_W       = 32;
  localparam int PATTERN_WORD_W = 64;
  localparam int PATTERN_WORDS  = 4;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 64;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_PATTERN_LENGTH = 3'd0;
  localparam cfg_index_t REG_PATTERN_WORD_0 = 3'd1;
  localparam cfg_index_t REG_PATTERN_WORD_1 = 3'd2;
  localparam cfg_index_t REG_PATTERN_WORD_2 = 3'd3;
  localparam cfg_index_t REG_PATTERN_WORD_3 = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0]   data_byte;
    logic                block_first;
    logic [ADDR_W-1:0]   base_address;
    logic [REGION_W-1:0] region_index;
  } scan_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   start_address;
    logic [REGION_W-1:0] match_region;
  } scan_out_t;

  // Control shared by every history cell
  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

endpackage

/* design/bps_cell.sv */
// ----------------------------------------------------------------------------
// bps_cell: one history cell of the scan window
// Holds one past byte of the block, compares it to its aligned pattern byte
// and passes it on to the next cell on every transfer.
// ----------------------------------------------------------------------------
module bps_cell
  import bps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              valid_in,
  input  logic [BYTE_W-1:0] ref_byte,
  input  logic              active,
  output logic [BYTE_W-1:0] byte_out,
  output logic              valid_out,
  output logic              hit
);

  logic [BYTE_W-1:0] hist_byte;
  logic              hist_valid;

  // A new block empties the window before the current byte is checked
  assign valid_out = hist_valid & ~ctrl.clear;
  assign byte_out  = hist_byte;
  assign hit       = ~active | (valid_out & (hist_byte == ref_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= 1'b0;
    end else if (ctrl.advance) begin
      hist_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      hist_byte <= byte_in;
    end
  end

endmodule

/* design/bps_out_buf.sv */
// ----------------------------------------------------------------------------
// bps_out_buf: two-entry result buffer
// Output register plus skid register, so the scanner keeps taking bytes
// while a result waits at the output.
// ----------------------------------------------------------------------------
module bps_out_buf
  import bps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scan_out_t push_item,
  output logic      space,
  output logic      out_valid,
  input  logic      out_ready,
  output scan_out_t out_item
);

  logic      skid_valid;
  scan_out_t skid_item;
  logic      pop;

  assign pop   = out_valid & out_ready;
  assign space = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid) begin
        out_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= push;
        end else begin
          out_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || (pop && !skid_valid)) begin
      out_item <= push_item;
    end else if (pop) begin
      out_item <= skid_item;
    end
    // hold or refill the skid entry
    if ((out_valid && !pop && push) || (pop && skid_valid && push)) begin
      skid_item <= push_item;
    end
  end

endmodule

/* design/byte_pattern_scanner_top.sv */
// ----------------------------------------------------------------------------
// byte_pattern_scanner_top: exact byte string search over a block stream
// Reports every occurrence of the configured pattern, overlaps included.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one scanned byte per transfer, with block start mark, block
//                 base address and region index.
//   out channel : one result per match: start address of the match and region.
//   cfg channel : register writes (length, four pattern words); always ready.
//                 Write only while no result is outstanding.
// Throughput: one byte per cycle while in_ready is high. The window is a chain
//   of 31 history cells shifting on every transfer, all compared against the
//   aligned pattern in the cycle the byte arrives.
// Result: the byte that ends a match pushes its result into the output buffer.
// Stall: a two-entry output buffer keeps in_ready high while one result
//   waits; in_ready drops only with two results pending.
// Reset: length 1, pattern zero, window empty, block offset zero, output empty.
// ----------------------------------------------------------------------------
module byte_pattern_scanner_top
  import bps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  scan_in_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output scan_out_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]                     pattern_length;
  logic [PATTERN_WORD_W-1:0]            pattern_word [PATTERN_WORDS];
  logic [PATTERN_MAX-1:0][BYTE_W-1:0]   pattern_bytes;
  logic [LEN_W-1:0]                     len_eff;
  logic [PATTERN_MAX-1:0]               active;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0]   ref_byte;
  logic [PATTERN_MAX-1:0][BYTE_W-1:0]   chain_byte;
  logic [PATTERN_MAX-1:0]               chain_valid;
  logic [PATTERN_MAX-1:0]               hits;
  logic [OFFSET_W-1:0]                  block_offset;
  logic [OFFSET_W-1:0]                  off_cur;
  logic [OFFSET_W-1:0]                  span;
  logic                                 accept;
  logic                                 match;
  cell_ctrl_t                           cell_ctrl;
  scan_out_t                            result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      for (int i = 0; i < PATTERN_WORDS; i++) begin
        pattern_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LEN_W-1:0];
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pattern_bytes = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};
  assign len_eff = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pattern_length;

  // Cell k sees the byte k places back; it must equal pattern byte len-1-k
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_align
    logic [LEN_W-1:0] idx;
    assign active[k]   = LEN_W'(k) < len_eff;
    assign idx         = LEN_W'(len_eff - LEN_W'(k) - LEN_W'(1));
    assign ref_byte[k] = pattern_bytes[idx[IDX_W-1:0]];
  end

  assign cell_ctrl.advance = accept;
  assign cell_ctrl.clear   = in_item.block_first;

  assign chain_byte[0]  = in_item.data_byte;
  assign chain_valid[0] = 1'b1;
  assign hits[0]        = ~active[0] | (in_item.data_byte == ref_byte[0]);

  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_cell
    bps_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .byte_in   (chain_byte[k-1]),
      .valid_in  (chain_valid[k-1]),
      .ref_byte  (ref_byte[k]),
      .active    (active[k]),
      .byte_out  (chain_byte[k]),
      .valid_out (chain_valid[k]),
      .hit       (hits[k])
    );
  end

  assign match = (len_eff != '0) & (&hits);

  // Offset of the current byte; saturate at the top
  assign off_cur = in_item.block_first ? '0 : block_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_offset <= '0;
    end else if (accept) begin
      block_offset <= (&off_cur) ? off_cur : off_cur + OFFSET_W'(1);
    end
  end

  // A hit implies off_cur >= len-1, so span never wraps
  assign span = off_cur - OFFSET_W'(len_eff) + OFFSET_W'(1);
  assign result.start_address = in_item.base_address + ADDR_W'(span);
  assign result.match_region  = in_item.region_index;

  bps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept & match),
    .push_item (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* design/bps_checker.sv */
// ----------------------------------------------------------------------------
// bps_checker: port-level checks of the byte pattern scanner
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module bps_checker
  import bps_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input scan_out_t             out_item
);

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_item))
    else $error("result changed while stalled");

  // Back pressure only with a result waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // A result follows a byte transfer
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transfer");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind byte_pattern_scanner_top bps_checker u_bps_checker (.*);

/* dv/byte_pattern_scanner_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_pattern_scanner_top_tb: self-checking bench for the byte pattern scanner
// Streams bytes through the scanner under several pattern settings and stall
// profiles, predicts every match start address and region, and compares each
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module byte_pattern_scanner_top_tb
  import bps_pkg::*;
();

  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PAT_BITS       = PATTERN_WORDS * PATTERN_WORD_W;

  typedef enum int {
    KIND_SINGLE,
    KIND_FULL,
    KIND_PERIODIC,
    KIND_LONG,
    KIND_DISABLED,
    KIND_SHORT
  } pattern_kind_e;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  scan_in_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  scan_out_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_index_t            cfg_index = REG_PATTERN_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predicted scanner state
  logic [LEN_W-1:0]    exp_len;
  logic [PAT_BITS-1:0] exp_pattern;
  logic [BYTE_W-1:0]   exp_window [HIST_DEPTH];
  logic [OFFSET_W-1:0] exp_offset;
  int                  exp_seen;

  scan_out_t pending_matches[$];

  int src_idle_pct  = 31;
  int sink_idle_pct = 70;
  int n_errors      = 0;
  int n_bytes       = 0;
  int n_matches     = 0;
  int n_writes      = 0;
  int idle_cycles   = 0;

  byte_pattern_scanner_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin : result_check
    scan_out_t exp_item;
    if (!rst && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        $error("unexpected result: start_address %h match_region %h",
               out_item.start_address, out_item.match_region);
        n_errors++;
      end else begin
        exp_item = pending_matches.pop_front();
        n_matches++;
        if (out_item.start_address !== exp_item.start_address) begin
          $error("start_address: expected %h, got %h",
                 exp_item.start_address, out_item.start_address);
          n_errors++;
        end
        if (out_item.match_region !== exp_item.match_region) begin
          $error("match_region: expected %h, got %h",
                 exp_item.match_region, out_item.match_region);
          n_errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // End the run when no channel has moved a transfer for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic scan_in_t scan_item(input logic [BYTE_W-1:0] d, input logic first,
                                         input logic [ADDR_W-1:0] base,
                                         input logic [REGION_W-1:0] region);
    scan_in_t b;
    b.data_byte    = d;
    b.block_first  = first;
    b.base_address = base;
    b.region_index = region;
    return b;
  endfunction

  function automatic logic [PAT_BITS-1:0] random_pattern();
    logic [PAT_BITS-1:0] pat;
    for (int w = 0; w < PAT_BITS / 32; w++) pat[w*32 +: 32] = $urandom;
    return pat;
  endfunction

  // Take one byte into the predicted window and queue the match it completes
  task automatic advance_window(input scan_in_t b);
    int        eff_len;
    bit        hit;
    scan_out_t m;
    if (b.block_first) begin
      foreach (exp_window[k]) exp_window[k] = '0;
      exp_offset = '0;
      exp_seen   = 0;
    end
    eff_len = (exp_len > PATTERN_MAX) ? PATTERN_MAX : int'(exp_len);
    if (eff_len != 0 && exp_seen + 1 >= eff_len) begin
      hit = (exp_pattern[(eff_len-1)*BYTE_W +: BYTE_W] == b.data_byte);
      for (int k = 1; k < eff_len; k++)
        if (exp_pattern[(eff_len-1-k)*BYTE_W +: BYTE_W] != exp_window[k-1]) hit = 1'b0;
      if (hit) begin
        m.start_address = b.base_address + ADDR_W'(exp_offset) - ADDR_W'(eff_len) + 64'd1;
        m.match_region  = b.region_index;
        pending_matches.insert(pending_matches.size(), m);
      end
    end
    for (int k = HIST_DEPTH - 1; k > 0; k--) exp_window[k] = exp_window[k-1];
    exp_window[0] = b.data_byte;
    if (exp_offset != '1) exp_offset++;
    if (exp_seen < PATTERN_MAX) exp_seen++;
  endtask

  // Leave in_valid high after the transfer; the next call or a drain lowers it
  task automatic push_byte(input scan_in_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= b;
    do @(posedge clk); while (!in_ready);
    advance_window(b);
    n_bytes++;
  endtask

  // Hold off the stream until every predicted match is out, then let it settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_LENGTH: exp_len = val[LEN_W-1:0];
      REG_PATTERN_WORD_0, REG_PATTERN_WORD_1, REG_PATTERN_WORD_2, REG_PATTERN_WORD_3:
        exp_pattern[(int'(idx) - int'(REG_PATTERN_WORD_0))*PATTERN_WORD_W +: PATTERN_WORD_W] = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic program_pattern(input logic [CFG_DATA_W-1:0] len_val,
                                 input logic [PAT_BITS-1:0] pat);
    write_reg(REG_PATTERN_LENGTH, len_val);
    for (int w = 0; w < PATTERN_WORDS; w++)
      write_reg(cfg_index_t'(int'(REG_PATTERN_WORD_0) + w),
                pat[w*PATTERN_WORD_W +: PATTERN_WORD_W]);
    // Sprinkle writes to unmapped indexes; they must change nothing
    if ($urandom_range(2) == 0)
      write_reg(cfg_index_t'($urandom_range(int'(REG_PATTERN_WORD_3) + 1,
                                            (1 << CFG_INDEX_W) - 1)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  // Length 1 and a zero pattern out of reset; bytes arrive with no block mark
  task automatic test_reset_state();
    push_byte(scan_item(8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF));
    push_byte(scan_item(8'hFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 16'h0000));
    // address wraps past the top of the address space
    push_byte(scan_item(8'h00, 1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF));
    drain_results();
  endtask

  task automatic test_unused_index();
    for (int u = int'(REG_PATTERN_WORD_3) + 1; u < (1 << CFG_INDEX_W); u++)
      write_reg(cfg_index_t'(u), '1);
    cfg_valid <= 1'b0;
    push_byte(scan_item(8'h00, 1'b1, 64'h0, 16'h0));
    drain_results();
  endtask

  // Upper data bits set, low six clear: length zero, no match even on zeros
  task automatic test_zero_length();
    program_pattern({{(CFG_DATA_W-LEN_W){1'b1}}, {LEN_W{1'b0}}}, '0);
    push_byte(scan_item(8'h00, 1'b1, 64'h0, 16'h0));
    push_byte(scan_item(8'h00, 1'b0, 64'h0, 16'h0));
    drain_results();
  endtask

  task automatic test_overlapping_matches();
    logic [PAT_BITS-1:0] pat;
    pat = random_pattern();
    pat[3*BYTE_W-1:0] = {3{8'h41}};
    program_pattern(64'd3, pat);
    for (int i = 0; i < 5; i++)
      push_byte(scan_item(8'h41, i == 0, 64'h0000_1000_0000_0000, 16'h1234));
    drain_results();
  endtask

  // A block mark splits the pattern; later base and region change mid-block
  task automatic test_block_boundary();
    logic [PAT_BITS-1:0] pat;
    pat = random_pattern();
    pat[2*BYTE_W-1:0] = 16'h4241;
    program_pattern(64'd2, pat);
    push_byte(scan_item(8'h41, 1'b1, 64'h10, 16'h0001));
    push_byte(scan_item(8'h42, 1'b1, 64'h20, 16'h0002));
    push_byte(scan_item(8'h41, 1'b0, 64'h20, 16'h0002));
    push_byte(scan_item(8'h42, 1'b0, 64'h8000_0000_0000_0000, 16'h00FF));
    drain_results();
  endtask

  task automatic test_byte_extremes();
    logic [PAT_BITS-1:0] pat;
    pat = random_pattern();
    pat[BYTE_W-1:0] = 8'hFF;
    program_pattern(64'd1, pat);
    push_byte(scan_item(8'hFF, 1'b1, 64'h0123_4567_89AB_CDEF, 16'h5A5A));
    push_byte(scan_item(8'h00, 1'b0, 64'h0123_4567_89AB_CDEF, 16'h5A5A));
    push_byte(scan_item(8'hFF, 1'b0, 64'h0123_4567_89AB_CDEF, 16'hA5A5));
    drain_results();
  endtask

  // Reprogram, then stream random bytes in which copies of the pattern are
  // planted, some of them broken by a stray byte or a block mark
  task automatic scan_segment(input pattern_kind_e kind, input int round_no);
    logic [PAT_BITS-1:0]   pat;
    logic [CFG_DATA_W-1:0] len_val;
    logic [ADDR_W-1:0]     base;
    logic [REGION_W-1:0]   region;
    scan_in_t              b;
    int                    n_items;
    int                    len;
    int                    period;
    int                    copy_pos;

    pat     = random_pattern();
    len_val = {$urandom, $urandom};
    n_items = 36;
    case (kind)
      KIND_SINGLE: len_val[LEN_W-1:0] = LEN_W'(1);
      KIND_FULL: begin
        // full window, then a length above the window that must clamp
        len_val[LEN_W-1:0] = (round_no == 0) ? LEN_W'(PATTERN_MAX) : '1;
        n_items = 90;
      end
      KIND_PERIODIC: begin
        len_val[LEN_W-1:0] = LEN_W'($urandom_range(2, 6));
        period = $urandom_range(1, 2);
        for (int j = period; j < PATTERN_MAX; j++)
          pat[j*BYTE_W +: BYTE_W] = pat[(j % period)*BYTE_W +: BYTE_W];
      end
      KIND_LONG: len_val[LEN_W-1:0] = LEN_W'($urandom_range(7, 31));
      KIND_DISABLED: begin
        if (round_no == 0) len_val[LEN_W-1:0] = '0;
        else len_val[LEN_W-1:0] = LEN_W'($urandom_range(1, PATTERN_MAX));
      end
      default: len_val[LEN_W-1:0] = LEN_W'($urandom_range(2, 12));
    endcase

    drain_results();
    program_pattern(len_val, pat);
    len = (len_val[LEN_W-1:0] > PATTERN_MAX) ? PATTERN_MAX : int'(len_val[LEN_W-1:0]);
    copy_pos = -1;
    base     = {$urandom, $urandom};
    region   = REGION_W'($urandom);

    for (int i = 0; i < n_items; i++) begin
      if (i == 0) b.block_first = ($urandom_range(1) == 1);
      else if (copy_pos < 0) b.block_first = ($urandom_range(24) == 0);
      else b.block_first = ($urandom_range(199) == 0);
      if (b.block_first || $urandom_range(15) == 0) begin
        case ($urandom_range(7))
          0:       base = '0;
          1:       base = '1;
          default: base = {$urandom, $urandom};
        endcase
        region = REGION_W'($urandom);
      end
      if (len != 0 && copy_pos < 0 && $urandom_range(99) < 35) copy_pos = 0;
      if (copy_pos >= 0) begin
        b.data_byte = ($urandom_range(4 * len) == 0) ? BYTE_W'($urandom)
                                                     : pat[copy_pos*BYTE_W +: BYTE_W];
        copy_pos = (copy_pos + 1 < len) ? copy_pos + 1 : -1;
      end else if (len != 0 && $urandom_range(1) == 1) begin
        b.data_byte = pat[$urandom_range(len - 1)*BYTE_W +: BYTE_W];
      end else begin
        b.data_byte = BYTE_W'($urandom);
      end
      b.base_address = base;
      b.region_index = region;
      push_byte(b);
    end
  endtask

  task automatic test_random_scan(input int src_pct, input int sink_pct,
                                  input int first_seg, input int n_seg);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int s = first_seg; s < first_seg + n_seg; s++)
      scan_segment(pattern_kind_e'(s % 6), s / 6);
  endtask

  initial begin
    exp_len     = LEN_W'(1);
    exp_pattern = '0;
    foreach (exp_window[k]) exp_window[k] = '0;
    exp_offset  = '0;
    exp_seen    = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_unused_index();
    test_zero_length();
    test_overlapping_matches();
    test_block_boundary();
    test_byte_extremes();
    test_random_scan(31, 70, 0, 4);
    test_random_scan(70, 31, 4, 4);
    test_random_scan(0, 0, 8, 4);
    drain_results();

    $display("Scanned %0d bytes, checked %0d matches, issued %0d register writes.",
             n_bytes, n_matches, n_writes);
    $display("Lengths 0 to 63 incl. clamped, overlaps, block splits, address wrap, 3 stall mixes.");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
